>>> sv/servo_brake_sequencer_assert.svh
// assertion macros for the servo brake sequencer
// expects clk and arst_n in the scope of each use
`ifndef SERVO_BRAKE_SEQUENCER_ASSERT_SVH
`define SERVO_BRAKE_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

`define SBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define SBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBS_ASSERT(lbl, prop, msg)

`define SBS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/sbs_pkg.sv
// shared types and constants for the servo brake sequencer
// no dependencies
package sbs_pkg;

	localparam logic [15:0] TICK_MS         = 16'd1;
	localparam logic [2:0]  ZERO_STOP_CODE  = 3'd1;
	localparam logic [15:0] TEST_RELEASE_MS = 16'd20;
	localparam logic [15:0] MS_MAX          = 16'hFFFF;

	localparam logic [2:0] CFG_MOTORLESS_TEST     = 3'd0;
	localparam logic [2:0] CFG_RELEASE_DELAY_MS   = 3'd1;
	localparam logic [2:0] CFG_ENGAGE_SPEED_LEVEL = 3'd2;
	localparam logic [2:0] CFG_ENGAGE_WAIT_MS     = 3'd3;
	localparam logic [2:0] CFG_ENGAGE_DELAY_MS    = 3'd4;
	localparam logic [2:0] CFG_OUTPUT_SELECT_MODE = 3'd5;

	typedef enum logic [2:0] {
		STEP_INIT     = 3'd0,
		STEP_WAIT     = 3'd1,
		STEP_RELEASED = 3'd2,
		STEP_SLOW     = 3'd3,
		STEP_ENGAGE   = 3'd4
	} step_t;

	typedef struct packed {
		logic        motorless_test;
		logic [15:0] release_delay_ms;
		logic [15:0] engage_speed_level;
		logic [15:0] engage_wait_ms;
		logic [15:0] engage_delay_ms;
		logic        output_select_mode;
	} sbs_cfg_t;

	typedef struct packed {
		step_t       step;
		logic [15:0] elapsed_ms;
		logic        brake_flag;
		logic        release_flag;
		logic        zero_stop_flag;
		logic        power_fail_latch;
	} sbs_state_t;

	typedef struct packed {
		logic        servo_on_request;
		logic        ready_ignoring_phase;
		logic        pwm_enabled;
		logic        base_enable;
		logic        alarm_zero_stop;
		logic        power_fail_event;
		logic [15:0] motor_speed_abs;
		logic [2:0]  stop_mode_code;
		logic        safe_torque_off;
		logic        torque_mode;
		logic        external_brake_select;
	} sbs_in_t;

	typedef struct packed {
		logic       brake_applied;
		logic       release_request;
		logic       zero_stop_request;
		logic       brake_output_releasing;
		logic [2:0] sequence_step;
		logic       power_fail_pending;
	} sbs_out_t;

endpackage

>>> sv/sbs_cfg_regs.sv
// configuration register bank for the servo brake sequencer
// depends on sbs_pkg
module sbs_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output sbs_pkg::sbs_cfg_t cfg
);
	import sbs_pkg::*;

	sbs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOTORLESS_TEST:     cfg_q.motorless_test     <= cfg_data[0];
				CFG_RELEASE_DELAY_MS:   cfg_q.release_delay_ms   <= cfg_data;
				CFG_ENGAGE_SPEED_LEVEL: cfg_q.engage_speed_level <= cfg_data;
				CFG_ENGAGE_WAIT_MS:     cfg_q.engage_wait_ms     <= cfg_data;
				CFG_ENGAGE_DELAY_MS:    cfg_q.engage_delay_ms    <= cfg_data;
				CFG_OUTPUT_SELECT_MODE: cfg_q.output_select_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/sbs_step_logic.sv
// next-state and result logic of the brake sequence, one tick per pass
// depends on sbs_pkg
module sbs_step_logic (
	input  sbs_pkg::sbs_cfg_t   cfg,
	input  sbs_pkg::sbs_state_t cur,
	input  sbs_pkg::sbs_in_t    tick,
	output sbs_pkg::sbs_state_t nxt,
	output sbs_pkg::sbs_out_t   result
);
	import sbs_pkg::*;

	logic        enabled;
	logic        forced;
	logic        pf;
	logic        go;
	logic [15:0] lim;
	logic [16:0] sum;
	logic [15:0] inc;

	assign enabled = tick.servo_on_request & tick.ready_ignoring_phase;
	assign forced  = tick.stop_mode_code > ZERO_STOP_CODE;
	assign pf      = cur.power_fail_latch | tick.power_fail_event;
	assign go      = cfg.motorless_test ? tick.base_enable : tick.pwm_enabled;
	assign lim     = cfg.motorless_test ? TEST_RELEASE_MS : cfg.release_delay_ms;
	assign sum     = {1'b0, cur.elapsed_ms} + {1'b0, TICK_MS};
	assign inc     = sum[16] ? MS_MAX : sum[15:0];

	always_comb begin
		nxt = cur;
		nxt.power_fail_latch = pf;
		case (cur.step)
			STEP_INIT: begin
				nxt.brake_flag     = 1'b1;
				nxt.zero_stop_flag = 1'b0;
				nxt.elapsed_ms     = '0;
				nxt.step           = STEP_WAIT;
			end
			STEP_WAIT: begin
				if (enabled) begin
					nxt.release_flag = 1'b1;
					if (go) begin
						nxt.elapsed_ms = inc;
						if (inc > lim) begin
							nxt.brake_flag = 1'b0;
							nxt.elapsed_ms = '0;
							nxt.step       = STEP_RELEASED;
						end
					end else begin
						nxt.elapsed_ms = '0;
					end
				end else begin
					nxt.release_flag = 1'b0;
					nxt.elapsed_ms   = '0;
				end
			end
			STEP_RELEASED: begin
				if (enabled || tick.alarm_zero_stop) begin
					nxt.step = STEP_RELEASED;
				end else if (pf) begin
					nxt.brake_flag = 1'b1;
					nxt.elapsed_ms = '0;
					nxt.step       = STEP_ENGAGE;
				end else if (tick.motor_speed_abs >= cfg.engage_speed_level) begin
					nxt.release_flag = 1'b0;
					nxt.step         = STEP_SLOW;
				end else if (forced || cfg.engage_delay_ms == '0 || tick.safe_torque_off) begin
					nxt.release_flag = 1'b0;
					nxt.brake_flag   = 1'b1;
					nxt.step         = STEP_WAIT;
				end else begin
					nxt.brake_flag     = 1'b1;
					nxt.zero_stop_flag = ~tick.torque_mode;
					nxt.step           = STEP_ENGAGE;
				end
			end
			STEP_SLOW: begin
				nxt.elapsed_ms = inc;
				if (inc >= cfg.engage_wait_ms ||
				    tick.motor_speed_abs <= cfg.engage_speed_level) begin
					nxt.brake_flag = 1'b1;
					nxt.elapsed_ms = '0;
					nxt.step       = STEP_WAIT;
				end
			end
			STEP_ENGAGE: begin
				nxt.elapsed_ms = inc;
				if ((pf && inc >= cfg.engage_delay_ms) ||
				    (!pf && (inc >= cfg.engage_delay_ms || forced || tick.safe_torque_off))) begin
					nxt.release_flag     = 1'b0;
					nxt.zero_stop_flag   = 1'b0;
					nxt.elapsed_ms       = '0;
					nxt.step             = STEP_WAIT;
					nxt.power_fail_latch = 1'b0;
				end
			end
			default: begin
				nxt = cur;
				nxt.power_fail_latch = pf;
			end
		endcase
	end

	always_comb begin
		result.brake_applied     = nxt.brake_flag;
		result.release_request   = nxt.release_flag;
		result.zero_stop_request = nxt.zero_stop_flag;
		if (!cfg.output_select_mode) begin
			result.brake_output_releasing = nxt.brake_flag | cfg.motorless_test;
		end else begin
			result.brake_output_releasing = ~tick.external_brake_select & ~tick.base_enable;
		end
		result.sequence_step      = nxt.step;
		result.power_fail_pending = nxt.power_fail_latch;
	end

endmodule

>>> sv/servo_brake_sequencer.sv
// servo holding-brake sequencer, top level
// path from tick transfer to result valid: input stage, then result stage (both registered)
// throughput: one tick per cycle unless the receiver stalls, set by the single-pass step logic between the stages
// reset: asynchronous, active low; step init, brake engaged, counter, flags,
// stage valids and configuration cleared
// depends on sbs_pkg, sbs_cfg_regs, sbs_step_logic, servo_brake_sequencer_assert.svh
module servo_brake_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  sbs_pkg::sbs_in_t tick_data,
	output logic             result_valid,
	input  logic             result_stall,
	output sbs_pkg::sbs_out_t result_data
);
	import sbs_pkg::*;

	`include "servo_brake_sequencer_assert.svh"

	sbs_cfg_t   cfg;
	sbs_state_t state_q;
	sbs_state_t state_nxt;
	sbs_out_t   result_nxt;
	sbs_in_t    tick_s1;
	logic       valid_s1;
	sbs_out_t   result_s2;
	logic       valid_s2;
	logic       advance;

	sbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbs_step_logic u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.tick   (tick_s1),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	assign advance    = valid_s1 & (~valid_s2 | ~result_stall);
	assign tick_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step             <= STEP_INIT;
			state_q.elapsed_ms       <= '0;
			state_q.brake_flag       <= 1'b1;
			state_q.release_flag     <= 1'b0;
			state_q.zero_stop_flag   <= 1'b0;
			state_q.power_fail_latch <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result_data  = result_s2;

	`SBS_ASSERT(a_released_brake_open, (state_q.step == STEP_RELEASED || state_q.step == STEP_SLOW) |-> !state_q.brake_flag, "brake applied in released or slow-down step")
	`SBS_ASSERT(a_engage_brake_closed, (state_q.step == STEP_ENGAGE) |-> state_q.brake_flag, "brake open in engaging step")
	`SBS_ASSERT(a_no_stall_when_empty, !valid_s2 |-> !tick_stall, "input stalled with empty result stage")
	`SBS_ASSERT(a_advance_fills, advance |=> valid_s2, "result stage not filled after transfer")
	`SBS_ASSERT(a_state_holds, !advance |=> $stable(state_q), "state moved without a tick")

endmodule

>>> verif/sbs_checker.sv
// checker for the servo brake sequencer: follows the tick and result channels
// and the register port, predicts each result and compares it field by field
// depends on sbs_pkg
module sbs_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              tick_valid,
	input  logic              tick_stall,
	input  sbs_pkg::sbs_in_t  tick_data,
	input  logic              result_valid,
	input  logic              result_stall,
	input  sbs_pkg::sbs_out_t result_data,
	output int                fails,
	output int                pending,
	output int                results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import sbs_pkg::*;

	sbs_cfg_t    regs;
	step_t       seq_step;
	logic [15:0] ms_count;
	logic        brake_on;
	logic        release_on;
	logic        zero_stop_on;
	logic        pf_latched;

	sbs_out_t brake_outputs_q[$];
	sbs_out_t want;
	sbs_out_t predicted;

	task automatic bump_ms();
		logic [16:0] sum;
		sum = {1'b0, ms_count} + {1'b0, TICK_MS};
		ms_count = (sum > {1'b0, MS_MAX}) ? MS_MAX : sum[15:0];
	endtask

	task automatic enter_wait_step();
		release_on = 1'b0;
		zero_stop_on = 1'b0;
		ms_count = '0;
		seq_step = STEP_WAIT;
	endtask

	task automatic predict_brake_tick(input sbs_in_t t, output sbs_out_t r);
		logic        enabled;
		logic        forced;
		logic        go;
		logic [15:0] limit;
		enabled = t.servo_on_request & t.ready_ignoring_phase;
		forced = t.stop_mode_code > ZERO_STOP_CODE;
		// power-fail event is latched before the step logic
		if (t.power_fail_event) pf_latched = 1'b1;
		case (seq_step)
			STEP_INIT: begin
				brake_on = 1'b1;
				zero_stop_on = 1'b0;
				ms_count = '0;
				seq_step = STEP_WAIT;
			end
			STEP_WAIT: begin
				if (enabled) begin
					go = regs.motorless_test ? t.base_enable : t.pwm_enabled;
					limit = regs.motorless_test ? TEST_RELEASE_MS : regs.release_delay_ms;
					release_on = 1'b1;
					if (go) begin
						bump_ms();
						if (ms_count > limit) begin
							brake_on = 1'b0;
							ms_count = '0;
							seq_step = STEP_RELEASED;
						end
					end else begin
						ms_count = '0;
					end
				end else begin
					release_on = 1'b0;
					ms_count = '0;
				end
			end
			STEP_RELEASED: begin
				if (enabled || t.alarm_zero_stop) begin
				end else if (pf_latched) begin
					brake_on = 1'b1;
					ms_count = '0;
					seq_step = STEP_ENGAGE;
				end else if (t.motor_speed_abs >= regs.engage_speed_level) begin
					release_on = 1'b0;
					seq_step = STEP_SLOW;
				end else if (forced || regs.engage_delay_ms == '0 || t.safe_torque_off) begin
					release_on = 1'b0;
					brake_on = 1'b1;
					seq_step = STEP_WAIT;
				end else begin
					brake_on = 1'b1;
					zero_stop_on = ~t.torque_mode;
					seq_step = STEP_ENGAGE;
				end
			end
			STEP_SLOW: begin
				bump_ms();
				if (ms_count >= regs.engage_wait_ms ||
						t.motor_speed_abs <= regs.engage_speed_level) begin
					brake_on = 1'b1;
					ms_count = '0;
					seq_step = STEP_WAIT;
				end
			end
			STEP_ENGAGE: begin
				bump_ms();
				if (pf_latched) begin
					if (ms_count >= regs.engage_delay_ms) begin
						enter_wait_step();
						pf_latched = 1'b0;
					end
				end else if (ms_count >= regs.engage_delay_ms || forced || t.safe_torque_off) begin
					enter_wait_step();
				end
			end
			default: begin
			end
		endcase
		r.brake_applied = brake_on;
		r.release_request = release_on;
		r.zero_stop_request = zero_stop_on;
		if (!regs.output_select_mode) r.brake_output_releasing = brake_on | regs.motorless_test;
		else r.brake_output_releasing = ~t.external_brake_select & ~t.base_enable;
		r.sequence_step = seq_step;
		r.power_fail_pending = pf_latched;
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v, got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			seq_step = STEP_INIT;
			ms_count = '0;
			brake_on = 1'b1;
			release_on = 1'b0;
			zero_stop_on = 1'b0;
			pf_latched = 1'b0;
			brake_outputs_q.delete();
			fails = 0;
			pending = 0;
			results_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MOTORLESS_TEST:     regs.motorless_test = cfg_data[0];
					CFG_RELEASE_DELAY_MS:   regs.release_delay_ms = cfg_data;
					CFG_ENGAGE_SPEED_LEVEL: regs.engage_speed_level = cfg_data;
					CFG_ENGAGE_WAIT_MS:     regs.engage_wait_ms = cfg_data;
					CFG_ENGAGE_DELAY_MS:    regs.engage_delay_ms = cfg_data;
					CFG_OUTPUT_SELECT_MODE: regs.output_select_mode = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (result_valid && !result_stall) begin
				if (brake_outputs_q.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none, actual %h",
						$time, result_data);
					fails++;
				end else begin
					want = brake_outputs_q.pop_front();
					check_field("brake_applied", 16'(want.brake_applied),
						16'(result_data.brake_applied));
					check_field("release_request", 16'(want.release_request),
						16'(result_data.release_request));
					check_field("zero_stop_request", 16'(want.zero_stop_request),
						16'(result_data.zero_stop_request));
					check_field("brake_output_releasing", 16'(want.brake_output_releasing),
						16'(result_data.brake_output_releasing));
					check_field("sequence_step", 16'(want.sequence_step),
						16'(result_data.sequence_step));
					check_field("power_fail_pending", 16'(want.power_fail_pending),
						16'(result_data.power_fail_pending));
					results_checked++;
				end
			end
			if (tick_valid && !tick_stall) begin
				predict_brake_tick(tick_data, predicted);
				brake_outputs_q.push_back(predicted);
			end
			pending = brake_outputs_q.size();
		end
	end

endmodule

>>> verif/tb_servo_brake_sequencer.sv
// testbench top for the servo brake sequencer: clock, reset, register setup,
// directed and random scan ticks with bursty sending and receiver stalls, verdict
// depends on sbs_pkg, servo_brake_sequencer and sbs_checker
module tb_servo_brake_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import sbs_pkg::*;

	typedef enum {SEG_RUN, SEG_STOP, SEG_NOISE} seg_kind_e;
	typedef enum {RX_FREE, RX_SPARSE, RX_BURSTY} rx_pattern_e;
	typedef enum {PH_DIRECTED, PH_ZERO, PH_MAX_MOTORLESS, PH_MAX, PH_RANDOM} phase_kind_e;

	localparam int PHASE_ITEMS = 170;
	localparam int RANDOM_PHASES = 6;
	localparam logic [2:0] STOP_NONE = 3'd0;
	localparam logic [2:0] STOP_HARD = 3'd7;
	localparam logic [2:0] CFG_FIRST_UNUSED = CFG_OUTPUT_SELECT_MODE + 3'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	sbs_in_t     tick_data = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	sbs_out_t    result_data;

	int fails;
	int pending;
	int results_checked;

	int unsigned burst_left = 0;
	int unsigned ticks_sent = 0;
	int unsigned phase_count = 0;
	logic [15:0] speed_level = '0;

	rx_pattern_e rx_pattern = RX_FREE;
	int unsigned rx_left = 0;
	int unsigned hold_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	servo_brake_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick_data    (tick_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	sbs_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.tick_valid      (tick_valid),
		.tick_stall      (tick_stall),
		.tick_data       (tick_data),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_data     (result_data),
		.fails           (fails),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// receiver stall pattern, switching between free, sparse and bursty stretches
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_pattern <= rx_pattern_e'($urandom_range(0, 2));
			rx_left <= $urandom_range(32, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_pattern)
			RX_FREE:   result_stall <= 1'b0;
			RX_SPARSE: result_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (hold_left == 0) begin
					result_stall <= ~result_stall;
					hold_left <= $urandom_range(0, 12);
				end else begin
					hold_left <= hold_left - 1;
				end
			end
		endcase
	end

	task automatic send_tick(input sbs_in_t t);
		int unsigned gap;
		@(negedge clk);
		tick_valid <= 1'b1;
		tick_data <= t;
		do @(posedge clk); while (tick_stall);
		ticks_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			tick_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) :
				$urandom_range(0, 12);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		tick_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] small_or_any(input int unsigned hi);
		return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, hi));
	endfunction

	task automatic program_phase(input phase_kind_e kind);
		logic        motorless;
		logic        out_sel;
		logic [15:0] rel;
		logic [15:0] lvl;
		logic [15:0] wt;
		logic [15:0] dly;
		case (kind)
			PH_DIRECTED: begin
				{motorless, out_sel} = 2'b00;
				rel = 16'd1;
				lvl = 16'd100;
				wt = 16'd3;
				dly = 16'd2;
			end
			PH_ZERO: begin
				{motorless, out_sel} = 2'b00;
				{rel, lvl, wt, dly} = '0;
			end
			PH_MAX_MOTORLESS: begin
				{motorless, out_sel} = 2'b10;
				{rel, lvl, wt, dly} = {4{MS_MAX}};
			end
			PH_MAX: begin
				{motorless, out_sel} = 2'b01;
				{rel, lvl, wt, dly} = {4{MS_MAX}};
			end
			default: begin
				motorless = 1'($urandom_range(0, 1));
				out_sel = 1'($urandom_range(0, 1));
				rel = small_or_any(6);
				lvl = 16'($urandom);
				wt = small_or_any(12);
				dly = ($urandom_range(0, 3) == 0) ? 16'd0 : small_or_any(8);
			end
		endcase
		drain_results();
		write_reg(CFG_MOTORLESS_TEST, {15'($urandom), motorless});
		write_reg(CFG_RELEASE_DELAY_MS, rel);
		write_reg(CFG_ENGAGE_SPEED_LEVEL, lvl);
		write_reg(CFG_ENGAGE_WAIT_MS, wt);
		write_reg(CFG_ENGAGE_DELAY_MS, dly);
		write_reg(CFG_OUTPUT_SELECT_MODE, {15'($urandom), out_sel});
		if ($urandom_range(0, 1)) write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 1)),
			16'($urandom));
		speed_level = lvl;
		phase_count++;
	endtask

	function automatic sbs_in_t mk_tick(input bit svon, pwm, base, alm, pf,
			input logic [15:0] speed, input logic [2:0] stop, input bit sto, trq, ext);
		sbs_in_t t;
		t.servo_on_request = svon;
		t.ready_ignoring_phase = svon;
		t.pwm_enabled = pwm;
		t.base_enable = base;
		t.alarm_zero_stop = alm;
		t.power_fail_event = pf;
		t.motor_speed_abs = speed;
		t.stop_mode_code = stop;
		t.safe_torque_off = sto;
		t.torque_mode = trq;
		t.external_brake_select = ext;
		return t;
	endfunction

	function automatic logic [15:0] speed_near_level();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return speed_level;
			2: return (speed_level == '0) ? speed_level : speed_level - 16'd1;
			3: return (speed_level == MS_MAX) ? speed_level : speed_level + 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sbs_in_t make_tick(input seg_kind_e kind);
		sbs_in_t t;
		t = sbs_in_t'($urandom);
		case (kind)
			SEG_RUN: begin
				t.servo_on_request = ($urandom_range(0, 15) != 0);
				t.ready_ignoring_phase = ($urandom_range(0, 15) != 0);
				t.pwm_enabled = ($urandom_range(0, 15) != 0);
				t.base_enable = ($urandom_range(0, 15) != 0);
				t.alarm_zero_stop = ($urandom_range(0, 7) == 0);
				t.power_fail_event = ($urandom_range(0, 63) == 0);
				if ($urandom_range(0, 3) != 0) t.stop_mode_code = STOP_NONE;
				t.safe_torque_off = ($urandom_range(0, 15) == 0);
			end
			SEG_STOP: begin
				t.servo_on_request = ($urandom_range(0, 7) == 0);
				t.alarm_zero_stop = ($urandom_range(0, 15) == 0);
				t.power_fail_event = ($urandom_range(0, 31) == 0);
				t.motor_speed_abs = speed_near_level();
				if ($urandom_range(0, 3) != 0) t.stop_mode_code = 3'($urandom_range(0, 1));
				t.safe_torque_off = ($urandom_range(0, 7) == 0);
			end
			default: begin
			end
		endcase
		return t;
	endfunction

	task automatic run_phase(input int unsigned n);
		int unsigned k;
		int unsigned len;
		int unsigned pick;
		seg_kind_e   kind;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				kind = SEG_RUN;
				len = $urandom_range(5, 40);
			end else if (pick < 85) begin
				kind = SEG_STOP;
				len = $urandom_range(2, 20);
			end else begin
				kind = SEG_NOISE;
				len = $urandom_range(1, 6);
			end
			if (len > n - k) len = n - k;
			repeat (len) begin
				send_tick(make_tick(kind));
				k++;
			end
		end
	endtask

	initial begin
		#500us;
		$display("tb_servo_brake_sequencer failed");
		$finish;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// delay 1, level 100, wait 3, hold 2
		program_phase(PH_DIRECTED);
		send_tick(mk_tick(0, 0, 0, 0, 0, 16'd0, STOP_NONE, 0, 0, 0));
		repeat (2) send_tick(mk_tick(1, 1, 1, 0, 0, 16'd0, STOP_NONE, 0, 0, 0));
		// slow-down left on timeout
		send_tick(mk_tick(0, 0, 0, 0, 0, 16'd200, STOP_NONE, 0, 0, 0));
		repeat (3) send_tick(mk_tick(0, 0, 0, 0, 0, 16'd150, STOP_NONE, 0, 0, 0));
		// engage with zero stop, hold time runs out
		repeat (2) send_tick(mk_tick(1, 1, 0, 0, 0, 16'd0, STOP_NONE, 0, 1, 0));
		repeat (3) send_tick(mk_tick(0, 0, 1, 0, 0, 16'd50, STOP_NONE, 0, 0, 1));
		// forced stop code engages at once
		repeat (2) send_tick(mk_tick(1, 1, 1, 0, 0, 16'd0, STOP_NONE, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 16'd50, STOP_HARD, 0, 0, 0));
		// alarm zero stop keeps released, then power fail latched through engage
		repeat (2) send_tick(mk_tick(1, 1, 1, 0, 0, 16'd0, STOP_NONE, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 1, 0, 16'd50, STOP_NONE, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 1, 16'd50, STOP_NONE, 0, 0, 0));
		repeat (2) send_tick(mk_tick(0, 0, 0, 0, 0, 16'd50, STOP_HARD, 0, 0, 0));
		// safe torque off engages at once
		repeat (2) send_tick(mk_tick(1, 1, 1, 0, 0, 16'd0, STOP_NONE, 0, 0, 0));
		send_tick(mk_tick(0, 0, 0, 0, 0, 16'd50, STOP_NONE, 1, 0, 0));
		send_tick(mk_tick(1, 1, 1, 1, 1, MS_MAX, STOP_HARD, 1, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 16'd0, STOP_NONE, 0, 0, 0));

		program_phase(PH_ZERO);
		run_phase(PHASE_ITEMS);
		program_phase(PH_MAX_MOTORLESS);
		run_phase(PHASE_ITEMS);
		program_phase(PH_MAX);
		run_phase(PHASE_ITEMS);
		repeat (RANDOM_PHASES) begin
			program_phase(PH_RANDOM);
			run_phase(PHASE_ITEMS);
		end

		drain_results();
		$display("summary: %0d scan ticks over %0d register settings, %0d results compared",
			ticks_sent, phase_count, results_checked);
		if (fails == 0) begin
			$display("tb_servo_brake_sequencer passed");
		end else begin
			$display("tb_servo_brake_sequencer failed");
		end
		$finish;
	end

endmodule
